@@ rtl/core/trimmed_mean_channel_filter_core_macros.svh @@
// Assertion helpers for the checker file of the filter core (tmcf_checker.sv).
// Both expect signals named clk and rst_n in the scope of use.
`ifndef TRIMMED_MEAN_CHANNEL_FILTER_CORE_MACROS_SVH
`define TRIMMED_MEAN_CHANNEL_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define TMCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tmcf_pkg.sv @@
`default_nettype none

package tmcf_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 4;
  localparam int CNT_W    = 5;

  // per-channel sample counter saturates here
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  // default geometry
  localparam int CHANNELS_DEF = 12;
  localparam int WINDOW_DEF   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TRIM_TWO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_MODE = 2'd1;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] filtered;
  } out_item_t;

  typedef struct packed {
    logic trim_two;
    logic report_mode;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/tmcf_window_ram.sv @@
`default_nettype none

// One row per channel, holding that channel's whole window. Registered read.
module tmcf_window_ram #(
  parameter int DEPTH = tmcf_pkg::CHANNELS_DEF,
  parameter int WIDTH = tmcf_pkg::WINDOW_DEF * tmcf_pkg::SAMPLE_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire tmcf_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [WIDTH-1:0]   rd_data,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [WIDTH-1:0]   wr_data
);
  import tmcf_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/tmcf_extreme_tree.sv @@
`default_nettype none

// Pairwise min or max tree over one window with an exclusion mask.
// On ties the lower (older) slot wins.
module tmcf_extreme_tree #(
  parameter int WINDOW   = tmcf_pkg::WINDOW_DEF,
  parameter bit FIND_MAX = 1'b0,
  localparam int PW      = $clog2(WINDOW)
) (
  input  wire logic [WINDOW*tmcf_pkg::SAMPLE_W-1:0] vals_i,
  input  wire logic [WINDOW-1:0]                    excl_i,
  output logic      [tmcf_pkg::SAMPLE_W-1:0]        val_o,
  output logic      [PW-1:0]                        pos_o
);
  import tmcf_pkg::*;

  localparam int PAD   = 1 << PW;
  localparam int PAD_W = PAD * SAMPLE_W;

  logic [WINDOW-1:0]   keep;
  logic [PAD-1:0]      keep_pad;
  logic [PAD_W-1:0]    vals_pad;
  logic [SAMPLE_W-1:0] node_val [PW+1][PAD];
  logic [PW-1:0]       node_pos [PW+1][PAD];
  logic                node_ok  [PW+1][PAD];

  assign keep     = ~excl_i;
  assign keep_pad = PAD'(keep);
  assign vals_pad = PAD_W'(vals_i);

  always_comb begin
    logic better;
    logic pick_b;
    node_val = '{default: '0};
    node_pos = '{default: '0};
    node_ok  = '{default: 1'b0};
    // leaves
    for (int i = 0; i < PAD; i++) begin
      node_val[0][i] = vals_pad[i*SAMPLE_W +: SAMPLE_W];
      node_pos[0][i] = PW'(i);
      node_ok[0][i]  = keep_pad[i];
    end
    // reduce, left child holds the lower slots
    for (int l = 0; l < PW; l++) begin
      for (int j = 0; j < (PAD >> (l + 1)); j++) begin
        if (FIND_MAX) begin
          better = node_val[l][2*j+1] > node_val[l][2*j];
        end else begin
          better = node_val[l][2*j+1] < node_val[l][2*j];
        end
        pick_b = !node_ok[l][2*j] || (node_ok[l][2*j+1] && better);
        node_val[l+1][j] = pick_b ? node_val[l][2*j+1] : node_val[l][2*j];
        node_pos[l+1][j] = pick_b ? node_pos[l][2*j+1] : node_pos[l][2*j];
        node_ok[l+1][j]  = node_ok[l][2*j] || node_ok[l][2*j+1];
      end
    end
  end

  assign val_o = node_val[PW][0];
  assign pos_o = node_pos[PW][0];

endmodule

`default_nettype wire

@@ rtl/core/tmcf_front.sv @@
`default_nettype none

// Request intake, window read-modify-write and per-channel bookkeeping.
module tmcf_front #(
  parameter int CHANNELS = tmcf_pkg::CHANNELS_DEF,
  parameter int WINDOW   = tmcf_pkg::WINDOW_DEF,
  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int ROW_W   = WINDOW * tmcf_pkg::SAMPLE_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tmcf_pkg::cfg_t           cfg,
  // request channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire tmcf_pkg::in_item_t       in_data,
  // window memory
  output tmcf_pkg::mem_ctl_t            mem_ctl,
  output logic [CH_AW-1:0]              rd_addr,
  input  wire logic [ROW_W-1:0]         rd_data,
  output logic [CH_AW-1:0]              wr_addr,
  output logic [ROW_W-1:0]              wr_data,
  // updated window toward the statistics stages
  output logic                          win_valid,
  input  wire logic                     win_ready,
  output logic [ROW_W-1:0]              win_row,
  output logic [tmcf_pkg::CH_W-1:0]     win_ch
);
  import tmcf_pkg::*;

  localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

  // read stage
  logic                s1_v_r;
  logic [CH_W-1:0]     s1_ch_r;
  logic [SAMPLE_W-1:0] s1_smp_r;
  // last row written, for a same-channel request right behind it
  logic                fwd_v_r;
  logic [CH_W-1:0]     fwd_ch_r;
  logic [ROW_W-1:0]    fwd_row_r;
  // per-channel flags and sample counts
  logic [CHANNELS-1:0] seen_r;
  logic [CNT_W-1:0]    count_r [CHANNELS];
  // output stage
  logic                o_v_r;
  logic [CH_W-1:0]     o_ch_r;
  logic [ROW_W-1:0]    o_row_r;

  logic             adv_out;
  logic             adv_s1;
  logic             accept;
  logic             in_range;
  logic [CH_AW-1:0] s1_addr;
  logic [ROW_W-1:0] old_row;
  logic [ROW_W-1:0] new_row;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] count_nxt;
  logic             emit;

  // handshake
  assign adv_out  = !o_v_r || win_ready;
  assign adv_s1   = !s1_v_r || adv_out;
  assign in_ready = adv_s1;
  assign accept   = in_valid && adv_s1;
  assign in_range = 32'(in_data.channel) < CHANNELS;
  assign s1_addr  = CH_AW'(s1_ch_r);

  // memory ports
  assign mem_ctl.rd_en = accept && in_range;
  assign mem_ctl.wr_en = adv_s1 && s1_v_r;
  assign rd_addr       = CH_AW'(in_data.channel);
  assign wr_addr       = s1_addr;
  assign wr_data       = new_row;

  // window update: fill on first sample, else shift oldest out
  always_comb begin
    old_row = (fwd_v_r && (fwd_ch_r == s1_ch_r)) ? fwd_row_r : rd_data;
    if (!seen_r[s1_addr]) begin
      new_row = {WINDOW{s1_smp_r}};
    end else begin
      new_row = {s1_smp_r, old_row[ROW_W-1:SAMPLE_W]};
    end
  end

  // sample count and report decision
  always_comb begin
    cnt_cur = count_r[s1_addr];
    cnt_inc = (cnt_cur < COUNT_MAX) ? cnt_cur + 5'd1 : cnt_cur;
    if (cfg.report_mode) begin
      emit      = cnt_inc >= WIN_CNT;
      count_nxt = emit ? '0 : cnt_inc;
    end else begin
      emit      = 1'b1;
      count_nxt = cnt_inc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      o_v_r   <= 1'b0;
      seen_r  <= '0;
      count_r <= '{default: '0};
    end else begin
      if (adv_s1) begin
        s1_v_r  <= accept && in_range;
        fwd_v_r <= s1_v_r;
      end
      if (adv_s1 && s1_v_r) begin
        seen_r[s1_addr]  <= 1'b1;
        count_r[s1_addr] <= count_nxt;
      end
      if (adv_out) begin
        o_v_r <= s1_v_r && emit;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch_r  <= in_data.channel;
      s1_smp_r <= in_data.sample;
    end
    if (adv_s1) begin
      fwd_ch_r  <= s1_ch_r;
      fwd_row_r <= new_row;
    end
    if (adv_out && s1_v_r) begin
      o_ch_r  <= s1_ch_r;
      o_row_r <= new_row;
    end
  end

  assign win_valid = o_v_r;
  assign win_row   = o_row_r;
  assign win_ch    = o_ch_r;

endmodule

`default_nettype wire

@@ rtl/core/tmcf_stats.sv @@
`default_nettype none

// Window sum and extremes, then the trimmed numerator. Three stages.
module tmcf_stats #(
  parameter int WINDOW  = tmcf_pkg::WINDOW_DEF,
  localparam int ROW_W  = WINDOW * tmcf_pkg::SAMPLE_W,
  localparam int NUM_W  = tmcf_pkg::SAMPLE_W + $clog2(WINDOW)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tmcf_pkg::cfg_t           cfg,
  input  wire logic                     win_valid,
  output logic                          win_ready,
  input  wire logic [ROW_W-1:0]         win_row,
  input  wire logic [tmcf_pkg::CH_W-1:0] win_ch,
  output logic                          num_valid,
  input  wire logic                     num_ready,
  output logic [NUM_W-1:0]              num_value,
  output logic [tmcf_pkg::CH_W-1:0]     num_ch
);
  import tmcf_pkg::*;

  localparam int LVL   = $clog2(WINDOW);
  localparam int PAD   = 1 << LVL;
  localparam int PAD_W = PAD * SAMPLE_W;

  // stage A: sum, first extremes
  logic                a_v_r;
  logic [NUM_W-1:0]    a_sum_r;
  logic [SAMPLE_W-1:0] a_lo_r;
  logic [SAMPLE_W-1:0] a_hi_r;
  logic [LVL-1:0]      a_lo_pos_r;
  logic [LVL-1:0]      a_hi_pos_r;
  logic [ROW_W-1:0]    a_row_r;
  logic [CH_W-1:0]     a_ch_r;
  // stage B: second extremes
  logic                b_v_r;
  logic [NUM_W-1:0]    b_base_r;
  logic [SAMPLE_W-1:0] b_lo2_r;
  logic [SAMPLE_W-1:0] b_hi2_r;
  logic [CH_W-1:0]     b_ch_r;
  // stage C: numerator
  logic                c_v_r;
  logic [NUM_W-1:0]    c_num_r;
  logic [CH_W-1:0]     c_ch_r;

  logic adv_a;
  logic adv_b;
  logic adv_c;

  logic [PAD_W-1:0]    row_pad;
  logic [NUM_W-1:0]    sum_lvl [LVL+1][PAD];
  logic [SAMPLE_W-1:0] lo_val;
  logic [SAMPLE_W-1:0] hi_val;
  logic [LVL-1:0]      lo_pos;
  logic [LVL-1:0]      hi_pos;
  logic [WINDOW-1:0]   excl_lo;
  logic [WINDOW-1:0]   excl_hi;
  logic [SAMPLE_W-1:0] lo2_val;
  logic [SAMPLE_W-1:0] hi2_val;
  logic [LVL-1:0]      lo2_pos;
  logic [LVL-1:0]      hi2_pos;

  assign adv_c     = !c_v_r || num_ready;
  assign adv_b     = !b_v_r || adv_c;
  assign adv_a     = !a_v_r || adv_b;
  assign win_ready = adv_a;

  // adder tree over the incoming window
  assign row_pad = PAD_W'(win_row);

  always_comb begin
    sum_lvl = '{default: '0};
    for (int i = 0; i < PAD; i++) begin
      sum_lvl[0][i] = NUM_W'(row_pad[i*SAMPLE_W +: SAMPLE_W]);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j < (PAD >> (l + 1)); j++) begin
        sum_lvl[l+1][j] = sum_lvl[l][2*j] + sum_lvl[l][2*j+1];
      end
    end
  end

  tmcf_extreme_tree #(.WINDOW(WINDOW), .FIND_MAX(1'b0)) u_min (
    .vals_i (win_row),
    .excl_i ('0),
    .val_o  (lo_val),
    .pos_o  (lo_pos)
  );

  tmcf_extreme_tree #(.WINDOW(WINDOW), .FIND_MAX(1'b1)) u_max (
    .vals_i (win_row),
    .excl_i ('0),
    .val_o  (hi_val),
    .pos_o  (hi_pos)
  );

  // second extremes skip the slot of the first one
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      excl_lo[k] = LVL'(k) == a_lo_pos_r;
      excl_hi[k] = LVL'(k) == a_hi_pos_r;
    end
  end

  tmcf_extreme_tree #(.WINDOW(WINDOW), .FIND_MAX(1'b0)) u_min2 (
    .vals_i (a_row_r),
    .excl_i (excl_lo),
    .val_o  (lo2_val),
    .pos_o  (lo2_pos)
  );

  tmcf_extreme_tree #(.WINDOW(WINDOW), .FIND_MAX(1'b1)) u_max2 (
    .vals_i (a_row_r),
    .excl_i (excl_hi),
    .val_o  (hi2_val),
    .pos_o  (hi2_pos)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (adv_a) a_v_r <= win_valid;
      if (adv_b) b_v_r <= a_v_r;
      if (adv_c) c_v_r <= b_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv_a && win_valid) begin
      a_sum_r    <= sum_lvl[LVL][0];
      a_lo_r     <= lo_val;
      a_hi_r     <= hi_val;
      a_lo_pos_r <= lo_pos;
      a_hi_pos_r <= hi_pos;
      a_row_r    <= win_row;
      a_ch_r     <= win_ch;
    end
    if (adv_b && a_v_r) begin
      b_base_r <= a_sum_r - NUM_W'(a_lo_r) - NUM_W'(a_hi_r);
      b_lo2_r  <= lo2_val;
      b_hi2_r  <= hi2_val;
      b_ch_r   <= a_ch_r;
    end
    if (adv_c && b_v_r) begin
      c_num_r <= cfg.trim_two ? b_base_r - NUM_W'(b_lo2_r) - NUM_W'(b_hi2_r) : b_base_r;
      c_ch_r  <= b_ch_r;
    end
  end

  assign num_valid = c_v_r;
  assign num_value = c_num_r;
  assign num_ch    = c_ch_r;

endmodule

`default_nettype wire

@@ rtl/core/tmcf_divider.sv @@
`default_nettype none

// Division by WINDOW-2 or WINDOW-4 through an exact reciprocal multiply:
// multiplier ceil(2^s/d) with s = numerator width + clog2(d) gives the
// truncated quotient with no correction step. Ends in the output register.
module tmcf_divider #(
  parameter int WINDOW = tmcf_pkg::WINDOW_DEF,
  localparam int NUM_W = tmcf_pkg::SAMPLE_W + $clog2(WINDOW)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tmcf_pkg::cfg_t            cfg,
  input  wire logic                      num_valid,
  output logic                           num_ready,
  input  wire logic [NUM_W-1:0]          num_value,
  input  wire logic [tmcf_pkg::CH_W-1:0] num_ch,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tmcf_pkg::out_item_t            out_data
);
  import tmcf_pkg::*;

  localparam int DIV1   = WINDOW - 2;
  localparam int DIV2   = WINDOW - 4;
  localparam int SH1    = NUM_W + $clog2(DIV1);
  localparam int SH2    = NUM_W + $clog2(DIV2);
  localparam int M_W    = SH1 + 1;
  localparam int PROD_W = NUM_W + M_W;
  localparam logic [M_W-1:0] MUL1 =
    M_W'(((64'd1 << SH1) + 64'(DIV1) - 64'd1) / 64'(DIV1));
  localparam logic [M_W-1:0] MUL2 =
    M_W'(((64'd1 << SH2) + 64'(DIV2) - 64'd1) / 64'(DIV2));

  logic              p_v_r;
  logic [PROD_W-1:0] p_prod_r;
  logic              p_trim_r;
  logic [CH_W-1:0]   p_ch_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              adv_o;
  logic              adv_p;
  logic [M_W-1:0]    mult_sel;
  logic [PROD_W-1:0] quot;

  assign adv_o     = !out_valid_r || out_ready;
  assign adv_p     = !p_v_r || adv_o;
  assign num_ready = adv_p;

  assign mult_sel = cfg.trim_two ? MUL2 : MUL1;
  assign quot     = p_trim_r ? (p_prod_r >> SH2) : (p_prod_r >> SH1);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_p) p_v_r       <= num_valid;
      if (adv_o) out_valid_r <= p_v_r;
    end
  end

  // product, then quotient into the output register
  always_ff @(posedge clk) begin
    if (adv_p && num_valid) begin
      p_prod_r <= PROD_W'(num_value) * PROD_W'(mult_sel);
      p_trim_r <= cfg.trim_two;
      p_ch_r   <= num_ch;
    end
    if (adv_o && p_v_r) begin
      out_data_r.out_channel <= p_ch_r;
      out_data_r.filtered    <= SAMPLE_W'(quot);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/trimmed_mean_channel_filter_core.sv @@
// Trimmed-mean filter with one sliding window per converter channel.
// Requests come in on in_valid/in_ready with a channel number and a sample;
// results leave on out_valid/out_ready with the channel and the mean of its
// window after dropping the smallest and largest value (two of each when
// trim_two is set). In report mode 1 a result is made only once per WINDOW
// samples of a channel; other requests update the window and yield nothing.
// Requests for a channel number of CHANNELS or more are taken and dropped.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 (trim_two) or
// 1 (report_mode), bit 0 of cfg_data; write only while the core is idle.
// Throughput: one request per clock while out_ready is high, set by the
// single read-modify-write of a channel's window row in the memory stage; a
// request for the channel just before it picks the new row from a
// forwarding register. Reset clears configuration, per-channel first-sample
// flags and counts and all pipeline valids; the window memory is not cleared,
// a channel's first sample fills its row. When out_ready is low the pipeline
// keeps accepting until every stage holds a request, then in_ready drops;
// nothing is lost.
`default_nettype none

module trimmed_mean_channel_filter_core #(
  parameter int CHANNELS = tmcf_pkg::CHANNELS_DEF,
  parameter int WINDOW   = tmcf_pkg::WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tmcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmcf_pkg::CFG_DATA_W-1:0] cfg_data,
  // requests
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tmcf_pkg::in_item_t              in_data,
  // results
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tmcf_pkg::out_item_t                  out_data
);
  import tmcf_pkg::*;

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W = WINDOW * SAMPLE_W;
  localparam int NUM_W = SAMPLE_W + $clog2(WINDOW);

  cfg_t cfg_r;

  mem_ctl_t         mem_ctl;
  logic [CH_AW-1:0] rd_addr;
  logic [ROW_W-1:0] rd_data;
  logic [CH_AW-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;

  logic             win_valid;
  logic             win_ready;
  logic [ROW_W-1:0] win_row;
  logic [CH_W-1:0]  win_ch;

  logic             num_valid;
  logic             num_ready;
  logic [NUM_W-1:0] num_value;
  logic [CH_W-1:0]  num_ch;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRIM_TWO:    cfg_r.trim_two    <= cfg_data[0];
        REG_REPORT_MODE: cfg_r.report_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tmcf_window_ram #(.DEPTH(CHANNELS), .WIDTH(ROW_W)) u_ram (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  tmcf_front #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_row   (win_row),
    .win_ch    (win_ch)
  );

  tmcf_stats #(.WINDOW(WINDOW)) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_row   (win_row),
    .win_ch    (win_ch),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num_value (num_value),
    .num_ch    (num_ch)
  );

  tmcf_divider #(.WINDOW(WINDOW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num_value (num_value),
    .num_ch    (num_ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/tmcf_checker.sv @@
`default_nettype none
`include "trimmed_mean_channel_filter_core_macros.svh"

// Port-level checks on the filter core.
module tmcf_checker #(
  parameter int CHANNELS = tmcf_pkg::CHANNELS_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire tmcf_pkg::out_item_t out_data
);
  import tmcf_pkg::*;

  // a stalled result holds
  `TMCF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // requests are refused only when the result side is blocked
  `TMCF_ASSERT_IMP(a_ready_backpressure, !in_ready, out_valid && !out_ready, "in_ready low without output stall")

  // results only for channels that exist
  `TMCF_ASSERT_IMP(a_out_channel, out_valid, 32'(out_data.out_channel) < CHANNELS, "result channel out of range")

endmodule

bind trimmed_mean_channel_filter_core tmcf_checker #(.CHANNELS(CHANNELS)) u_tmcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
